/* rtl/core/pma_pkg.sv */
// package for the prime-field arithmetic unit
// payload structs, action codes, sequencer states and multiply unit request
// no dependencies
`default_nettype none

package pma_pkg;

  localparam logic [30:0] MOD_RESET = 31'd998244353;
  localparam logic [6:0]  RED_LEN   = 7'd64;
  localparam logic [6:0]  MUL_LEN   = 7'd31;

  typedef enum logic [3:0] {
    ACT_RED = 4'd0,
    ACT_ADD = 4'd1,
    ACT_SUB = 4'd2,
    ACT_MUL = 4'd3,
    ACT_DIV = 4'd4,
    ACT_POW = 4'd5,
    ACT_NEG = 4'd6,
    ACT_INV = 4'd7,
    ACT_EQ  = 4'd8,
    ACT_NE  = 4'd9,
    ACT_LT  = 4'd10
  } pma_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_POW_CHK,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_MUL,
    ST_FINISH
  } pma_state_e;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } pma_in_t;

  typedef struct packed {
    logic [30:0] result;
    logic        truth;
    logic        error;
  } pma_out_t;

  // request to the shared double-and-add unit: bits are consumed msb first
  typedef struct packed {
    logic [63:0] bits;
    logic [6:0]  len;
    logic [30:0] mult;
  } pma_mreq_t;

endpackage

`default_nettype wire

/* rtl/core/pma_mulmod.sv */
// shared modular double-and-add unit, one bit of the request per cycle
// computes (bits * mult) mod modulus with acc = 2*acc + bit*mult each step
// depends on pma_pkg
`default_nettype none

module pma_mulmod
  import pma_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire pma_mreq_t   req_i,
  input  wire logic [30:0] mod_i,
  output logic             done_o,
  output logic [30:0]      res_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] sh_q;
  logic [30:0] y_q;
  logic [30:0] acc_q, acc_d;
  logic [32:0] sum_w;
  logic [32:0] mod1_w;
  logic [32:0] mod2_w;

  assign mod1_w = {2'b00, mod_i};
  assign mod2_w = {1'b0, mod_i, 1'b0};
  assign sum_w  = {1'b0, acc_q, 1'b0} + (sh_q[63] ? {2'b00, y_q} : 33'd0);

  // sum stays below three times the modulus
  always_comb begin
    if (sum_w >= mod2_w) begin
      acc_d = 31'(sum_w - mod2_w);
    end else if (sum_w >= mod1_w) begin
      acc_d = 31'(sum_w - mod1_w);
    end else begin
      acc_d = 31'(sum_w);
    end
  end

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = req_i.len;
    end else if (run_q) begin
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= req_i.bits;
      y_q   <= req_i.mult;
      acc_q <= '0;
    end else if (run_q) begin
      sh_q  <= {sh_q[62:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

`default_nettype wire

/* rtl/core/prime_modular_arithmetic_unit.sv */
// top level of the prime-field arithmetic unit: sequencer, operand registers, output stage
// depends on pma_pkg and pma_mulmod
`default_nettype none

// usage
// - in channel (in_valid_i/in_ready_o/in_data_i): action and two signed 64-bit operands
// - out channel (out_valid_o/out_ready_i/out_data_o): result residue, truth and error flags
// - cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): prime modulus, always ready; the
//   user writes it only while no item is in flight, unenforced; modulus zero acts as one
// - one item at a time; in_ready_o is high only while the sequencer is idle
// - every operation runs on one double-and-add unit that handles one bit per cycle
// - reduce, add, sub, neg, compares, undefined actions and a negative exponent finish
//   after the two operand reductions; mul adds one modular multiply
// - pow: square-and-multiply from the lsb, a multiply per set exponent bit and a square
//   per bit below the top one; a zero exponent gives one; inv uses modulus - 2 as
//   exponent; div raises b to modulus - 2 and then multiplies by a
// - the next transfer can be taken in the cycle after the result is loaded
// - a finished result sits in an output register, so the next item is taken while
//   the receiver stalls; the sequencer waits only if a second result is ready first
// - reset clears the sequencer and output valid and loads the modulus with 998244353

module prime_modular_arithmetic_unit
  import pma_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire pma_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output pma_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [30:0] cfg_data_i
);

  pma_state_e  state_q, state_d;
  logic [30:0] mod_q;
  logic [30:0] m_eff;
  logic [3:0]  act_q, act_d;
  logic        neg_a_q, neg_a_d;
  logic [63:0] raw_b_q, raw_b_d;
  logic [30:0] a_q, a_d;
  logic [30:0] b_q, b_d;
  logic [30:0] sq_q, sq_d;
  logic [30:0] pacc_q, pacc_d;
  logic [62:0] exp_q, exp_d;
  logic [30:0] res_q, res_d;
  logic        err_q, err_d;
  logic        out_valid_q;
  pma_out_t    out_q;
  pma_out_t    fin_w;
  logic        out_load;

  logic        m_start;
  pma_mreq_t   m_req;
  logic        m_done;
  logic [30:0] m_res;

  logic [63:0] ua_w;
  logic [63:0] mag_a_w;
  logic [63:0] mag_b_w;
  logic        neg_sel;
  logic [30:0] fix_res;
  logic [62:0] inv_exp;
  logic [30:0] one_m;
  logic [31:0] sum_ab;
  logic [31:0] dif_ab;
  logic [31:0] mod_ext;

  function automatic pma_mreq_t mul_req(input logic [30:0] x, input logic [30:0] y);
    pma_mreq_t r;
    r.bits = {x, 33'd0};
    r.len  = MUL_LEN;
    r.mult = y;
    return r;
  endfunction

  function automatic pma_mreq_t red_req(input logic [63:0] mag);
    pma_mreq_t r;
    r.bits = mag;
    r.len  = RED_LEN;
    r.mult = 31'd1;
    return r;
  endfunction

  pma_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (m_start),
    .req_i   (m_req),
    .mod_i   (m_eff),
    .done_o  (m_done),
    .res_o   (m_res)
  );

  assign m_eff   = (mod_q == 31'd0) ? 31'd1 : mod_q;
  assign mod_ext = {1'b0, m_eff};
  assign one_m   = {30'd0, (m_eff != 31'd1)};
  assign inv_exp = (m_eff >= 31'd2) ? {32'd0, m_eff - 31'd2} : 63'd0;

  assign ua_w    = in_data_i.operand_a;
  assign mag_a_w = ua_w[63] ? (~ua_w + 64'd1) : ua_w;
  assign mag_b_w = raw_b_q[63] ? (~raw_b_q + 64'd1) : raw_b_q;

  // negative operands with a nonzero residue r wrap up to modulus - r
  assign neg_sel = (state_q == ST_RED_A) ? neg_a_q : raw_b_q[63];
  assign fix_res = (neg_sel && m_res != 31'd0) ? (m_eff - m_res) : m_res;

  assign sum_ab = {1'b0, a_q} + {1'b0, b_q};
  assign dif_ab = {1'b0, a_q} + (mod_ext - {1'b0, b_q});

  always_comb begin
    fin_w = '0;
    case (act_q)
      ACT_RED: fin_w.result = a_q;
      ACT_ADD: fin_w.result = (sum_ab >= mod_ext) ? 31'(sum_ab - mod_ext) : 31'(sum_ab);
      ACT_SUB: fin_w.result = (dif_ab >= mod_ext) ? 31'(dif_ab - mod_ext) : 31'(dif_ab);
      ACT_MUL, ACT_DIV, ACT_INV: fin_w.result = res_q;
      ACT_POW: begin
        fin_w.result = res_q;
        fin_w.error  = err_q;
      end
      ACT_NEG: fin_w.result = (a_q != 31'd0) ? (m_eff - a_q) : 31'd0;
      ACT_EQ:  fin_w.truth  = (a_q == b_q);
      ACT_NE:  fin_w.truth  = (a_q != b_q);
      ACT_LT:  fin_w.truth  = (a_q < b_q);
      default: fin_w = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    neg_a_d  = neg_a_q;
    raw_b_d  = raw_b_q;
    a_d      = a_q;
    b_d      = b_q;
    sq_d     = sq_q;
    pacc_d   = pacc_q;
    exp_d    = exp_q;
    res_d    = res_q;
    err_d    = err_q;
    m_start  = 1'b0;
    m_req    = red_req(mag_a_w);
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d   = in_data_i.action;
          neg_a_d = ua_w[63];
          raw_b_d = in_data_i.operand_b;
          err_d   = 1'b0;
          res_d   = '0;
          m_start = 1'b1;
          m_req   = red_req(mag_a_w);
          state_d = ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (m_done) begin
          a_d     = fix_res;
          m_start = 1'b1;
          m_req   = red_req(mag_b_w);
          state_d = ST_RED_B;
        end
      end
      ST_RED_B: begin
        if (m_done) begin
          b_d    = fix_res;
          pacc_d = one_m;
          case (act_q)
            ACT_MUL: begin
              m_start = 1'b1;
              m_req   = mul_req(a_q, fix_res);
              state_d = ST_MUL;
            end
            ACT_POW: begin
              if (raw_b_q[63]) begin
                err_d   = 1'b1;
                state_d = ST_FINISH;
              end else begin
                sq_d    = a_q;
                exp_d   = raw_b_q[62:0];
                state_d = ST_POW_CHK;
              end
            end
            ACT_DIV: begin
              sq_d    = fix_res;
              exp_d   = inv_exp;
              state_d = ST_POW_CHK;
            end
            ACT_INV: begin
              sq_d    = a_q;
              exp_d   = inv_exp;
              state_d = ST_POW_CHK;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_POW_CHK: begin
        if (exp_q == 63'd0) begin
          if (act_q == ACT_DIV) begin
            m_start = 1'b1;
            m_req   = mul_req(a_q, pacc_q);
            state_d = ST_MUL;
          end else begin
            res_d   = pacc_q;
            state_d = ST_FINISH;
          end
        end else if (exp_q[0]) begin
          m_start = 1'b1;
          m_req   = mul_req(pacc_q, sq_q);
          state_d = ST_POW_MUL;
        end else begin
          m_start = 1'b1;
          m_req   = mul_req(sq_q, sq_q);
          state_d = ST_POW_SQR;
        end
      end
      ST_POW_MUL: begin
        if (m_done) begin
          pacc_d = m_res;
          if (exp_q[62:1] == 62'd0) begin
            exp_d   = '0;
            state_d = ST_POW_CHK;
          end else begin
            m_start = 1'b1;
            m_req   = mul_req(sq_q, sq_q);
            state_d = ST_POW_SQR;
          end
        end
      end
      ST_POW_SQR: begin
        if (m_done) begin
          sq_d    = m_res;
          exp_d   = {1'b0, exp_q[62:1]};
          state_d = ST_POW_CHK;
        end
      end
      ST_MUL: begin
        if (m_done) begin
          res_d   = m_res;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mod_q       <= MOD_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
      if (cfg_valid_i) begin
        mod_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    neg_a_q <= neg_a_d;
    raw_b_q <= raw_b_d;
    a_q     <= a_d;
    b_q     <= b_d;
    sq_q    <= sq_d;
    pacc_q  <= pacc_d;
    exp_q   <= exp_d;
    res_q   <= res_d;
    err_q   <= err_d;
    if (out_load) begin
      out_q <= fin_w;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef NO_ASSERTIONS
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.result == 31'd0 && !out_data_o.truth)
    else $error("error result carries residue or truth");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.result < m_eff)
    else $error("result not below modulus");

  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_done |-> (state_q == ST_RED_A || state_q == ST_RED_B || state_q == ST_POW_MUL ||
                state_q == ST_POW_SQR || state_q == ST_MUL))
    else $error("multiply unit finished outside a wait state");
`endif

endmodule

`default_nettype wire
